// File: rtl/current_knot_search_unit_macros.svh
// Assertion macros for the knot search block
`ifndef CURRENT_KNOT_SEARCH_UNIT_MACROS_SVH
`define CURRENT_KNOT_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CKS_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("knot search check failed");

// next-cycle implication, checked out of reset
`define CKS_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knot search check failed");

`endif

// File: rtl/cks_pkg.sv
// Package: codes, state type and double compare helpers for the knot search block
package cks_pkg;

  localparam int MAX_KNOTS_DEF = 256;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NONE  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ORDER = 3'd3;
  localparam logic [2:0] ST_VALUE = 3'd4;

  localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APP_CMP,
    S_QUERY
  } cks_state_t;

  function automatic logic f_is_nan(input logic [63:0] x);
    f_is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic f_finite(input logic [63:0] x);
    f_finite = (x[62:52] != 11'h7FF);
  endfunction

  // order key: unsigned compare of keys follows numeric order except for signed zeros
  function automatic logic [63:0] f_key(input logic [63:0] x);
    f_key = x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

  function automatic logic f_ge(input logic [63:0] a, input logic [63:0] b);
    logic zz;
    zz = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    f_ge = !f_is_nan(a) && !f_is_nan(b) && (zz || (f_key(a) >= f_key(b)));
  endfunction

  function automatic logic f_gt(input logic [63:0] a, input logic [63:0] b);
    logic zz;
    zz = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    f_gt = !f_is_nan(a) && !f_is_nan(b) && !zz && (f_key(a) > f_key(b));
  endfunction

endpackage

// File: rtl/cks_knot_ram.sv
// Knot time store: one write port, one registered read port
module cks_knot_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cks_fadd.sv
// Five-stage double precision adder, round to nearest even, with tag and flush
module cks_fadd #(
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          flush,
  input  logic          in_valid,
  input  logic [TW-1:0] in_tag,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          out_valid,
  output logic [TW-1:0] out_tag,
  output logic [63:0]   sum
);
  typedef struct packed {
    logic nan;
    logic inf;
    logic sign;
    logic zsign;
  } cks_flags_t;

  // stage 1: unpack, order by magnitude, align
  logic          v1;
  logic [TW-1:0] t1;
  cks_flags_t    f1;
  logic          sub1;
  logic [11:0]   e1;
  logic [55:0]   mb1, ms1;

  logic [63:0] big, sml;
  logic [10:0] eb, es, d;
  logic [5:0]  sh;
  logic [55:0] mb, ms, msk;
  logic        a_inf, b_inf;

  always_comb begin
    if (a[62:0] >= b[62:0]) begin
      big = a; sml = b;
    end else begin
      big = b; sml = a;
    end
    eb = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    d  = eb - es;
    sh = (d > 11'd56) ? 6'd56 : d[5:0];
    mb = {big[62:52] != 11'd0, big[51:0], 3'b000};
    ms = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
    msk = ~({56{1'b1}} << sh);
    a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    t1   <= in_tag;
    sub1 <= a[63] ^ b[63];
    e1   <= {1'b0, eb};
    mb1  <= mb;
    ms1  <= (ms >> sh) | {55'd0, |(ms & msk)};
    f1.nan   <= cks_pkg::f_is_nan(a) || cks_pkg::f_is_nan(b) ||
                (a_inf && b_inf && (a[63] ^ b[63]));
    f1.inf   <= a_inf || b_inf;
    f1.sign  <= big[63];
    f1.zsign <= a[63] & b[63];
  end

  // stage 2: add or subtract magnitudes
  logic          v2;
  logic [TW-1:0] t2;
  cks_flags_t    f2;
  logic [11:0]   e2;
  logic [56:0]   s2;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    t2 <= t1;
    f2 <= f1;
    e2 <= e1;
    s2 <= sub1 ? ({1'b0, mb1} - {1'b0, ms1}) : ({1'b0, mb1} + {1'b0, ms1});
  end

  // stage 3: carry out fix-up and leading zero count
  logic          v3;
  logic [TW-1:0] t3;
  cks_flags_t    f3;
  logic [11:0]   e3;
  logic [55:0]   n3;
  logic [5:0]    sh3;
  logic          z3;

  logic [5:0]  lz;
  logic [11:0] lim;

  always_comb begin
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (s2[i]) begin
        lz = 6'(55 - i);
      end
    end
    lim = e2 - 12'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    t3 <= t2;
    f3 <= f2;
    z3 <= (s2 == 57'd0);
    if (s2[56]) begin
      n3  <= {s2[56:2], s2[1] | s2[0]};
      e3  <= e2 + 12'd1;
      sh3 <= 6'd0;
    end else begin
      n3  <= s2[55:0];
      e3  <= e2;
      sh3 <= ({6'd0, lz} > lim) ? lim[5:0] : lz;
    end
  end

  // stage 4: normalising shift
  logic          v4;
  logic [TW-1:0] t4;
  cks_flags_t    f4;
  logic [11:0]   e4;
  logic [55:0]   n4;
  logic          z4;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    t4 <= t3;
    f4 <= f3;
    z4 <= z3;
    n4 <= n3 << sh3;
    e4 <= e3 - {6'd0, sh3};
  end

  // stage 5: round and pack
  logic [53:0] mr;
  logic [11:0] ef;
  logic [51:0] fr;
  logic [63:0] res;

  always_comb begin
    mr = {1'b0, n4[55:3]} + {53'd0, n4[2] & (n4[1] | n4[0] | n4[3])};
    if (mr[53]) begin
      ef = e4 + 12'd1;
      fr = mr[52:1];
    end else if (mr[52]) begin
      ef = e4;
      fr = mr[51:0];
    end else begin
      ef = 12'd0;
      fr = mr[51:0];
    end
    if (f4.nan) begin
      res = cks_pkg::QNAN;
    end else if (f4.inf || ef >= 12'd2047) begin
      res = {f4.sign, 11'h7FF, 52'd0};
    end else if (z4) begin
      res = {f4.zsign, 63'd0};
    end else begin
      res = {f4.sign, ef[10:0], fr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_tag <= t4;
    sum     <= res;
  end
endmodule

// File: rtl/current_knot_search_unit.sv
// Knot time table with append, clear and current-knot query
//
// Usage:
//   Items go in on start/command/time_bits, taken when start is high and busy low.
//   Each item gives one result: done pulses for one cycle with status and knot_index.
//   Results cannot be held off; the receiver takes each one in its done cycle.
//   Clear, unused codes, queries on an empty table, appends to an empty table and
//   appends refused as full or non-finite: result in the cycle after the transfer.
//   Other appends: one read of the last stored time from the knot memory, then
//   the compare.
//   Query: knot memory reads issue one per cycle into a five-stage double adder,
//   and the first stored time whose sum with epoch reaches the query time ends
//   the walk early with its index; otherwise the last index is returned.
//   busy stays high until the result is out.
//   epoch is written over the APB port at byte address 0 (64-bit data).
//   Reset empties the table and sets epoch to +0.0; the knot memory is not
//   cleared, entries past the count are never read.
module current_knot_search_unit
  import cks_pkg::*;
#(
  parameter int MAX_KNOTS = cks_pkg::MAX_KNOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] time_bits,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  knot_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  `include "current_knot_search_unit_macros.svh"

  localparam int IDX_W = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CNT_W = $clog2(MAX_KNOTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KNOTS);

  cks_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] issue, issue_next;
  logic [63:0]      held, held_next;
  logic             rd_valid, rd_valid_next;
  logic [IDX_W-1:0] rd_tag, rd_tag_next;
  logic             done_next;
  logic [2:0]       status_next;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] idx_out;
  logic [63:0]      epoch;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [63:0]      rdata;
  logic             sum_valid, flush;
  logic [IDX_W-1:0] sum_tag;
  logic [63:0]      sum;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W+7:0] idx_ext;
  logic             accept;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign prdata  = paddr[3] ? 64'd0 : epoch;
  assign cnt_m1  = count - CNT_W'(1);
  assign waddr   = count[IDX_W-1:0];
  assign idx_ext = {8'd0, idx_out};
  assign knot_index = idx_ext[7:0];

  cks_knot_ram #(.DEPTH(MAX_KNOTS), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (held_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  cks_fadd #(.TW(IDX_W)) u_fadd (
    .clk       (clk),
    .rst       (rst),
    .flush     (flush),
    .in_valid  (rd_valid),
    .in_tag    (rd_tag),
    .a         (epoch),
    .b         (rdata),
    .out_valid (sum_valid),
    .out_tag   (sum_tag),
    .sum       (sum)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    issue_next    = issue;
    held_next     = held;
    rd_valid_next = 1'b0;
    rd_tag_next   = issue[IDX_W-1:0];
    done_next     = 1'b0;
    status_next   = ST_OK;
    idx_next      = '0;
    we            = 1'b0;
    flush         = 1'b0;
    raddr         = cnt_m1[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          held_next = time_bits;
          case (command)
            CMD_APPEND: begin
              if (count >= MAX_CNT) begin
                done_next   = 1'b1;
                status_next = ST_FULL;
              end else if (!f_finite(time_bits)) begin
                done_next   = 1'b1;
                status_next = ST_VALUE;
              end else if (count == '0) begin
                we          = 1'b1;
                count_next  = count + CNT_W'(1);
                done_next   = 1'b1;
              end else begin
                state_next  = S_APP_CMP;
              end
            end
            CMD_QUERY: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = ST_NONE;
              end else begin
                issue_next  = '0;
                state_next  = S_QUERY;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              done_next  = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_APP_CMP: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (f_gt(held, rdata)) begin
          we         = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          status_next = ST_ORDER;
        end
      end
      S_QUERY: begin
        raddr = issue[IDX_W-1:0];
        if (sum_valid && (f_ge(sum, held) || sum_tag == cnt_m1[IDX_W-1:0])) begin
          done_next  = 1'b1;
          idx_next   = sum_tag;
          flush      = 1'b1;
          state_next = S_IDLE;
        end else if (issue < count) begin
          rd_valid_next = 1'b1;
          issue_next    = issue + CNT_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
      epoch    <= 64'd0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
      done     <= done_next;
      if (psel && penable && pwrite && pready && !paddr[3]) begin
        epoch <= pwdata;
      end
    end
    issue   <= issue_next;
    held    <= held_next;
    rd_tag  <= rd_tag_next;
    status  <= status_next;
    idx_out <= idx_next;
  end

  `CKS_CHECK(a_count_max, 1'b1, count <= MAX_CNT)
  `CKS_CHECK(a_sum_in_query, sum_valid, state == S_QUERY)
  `CKS_CHECK_NEXT(a_clear_result, accept && command == CMD_CLEAR, done && count == '0)
  `CKS_CHECK(a_none_index, done && status == ST_NONE, knot_index == 8'd0)
endmodule

// File: verif/tb_current_knot_search_unit.sv
// Self-checking testbench for the knot search block: predicted status and index
`timescale 1ns / 100ps
module tb_current_knot_search_unit;
  import cks_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DEPTH = 256;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [2:0] st;
    logic [7:0] idx;
  } knot_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [63:0] time_bits;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  knot_index;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic [63:0]  model_knots [DEPTH];
  int           model_count;
  logic [63:0]  model_epoch;
  knot_result_t pending_results [$];
  int           mismatches;
  int           idle_cycles;

  current_knot_search_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .time_bits(time_bits), .done(done), .status(status), .knot_index(knot_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_nan_bits(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic knot_result_t predict_knot_result(input logic [1:0] cmd,
                                                       input logic [63:0] t);
    knot_result_t r;
    logic [63:0] sum;
    int found;
    r.st = ST_OK;
    r.idx = 8'd0;
    case (cmd)
      CMD_APPEND: begin
        if (model_count >= DEPTH) r.st = ST_FULL;
        else if (t[62:52] == 11'h7FF) r.st = ST_VALUE;
        else if (model_count > 0 &&
                 !($bitstoreal(t) > $bitstoreal(model_knots[model_count-1])))
          r.st = ST_ORDER;
        else begin
          model_knots[model_count] = t;
          model_count++;
        end
      end
      CMD_QUERY: begin
        if (model_count == 0) r.st = ST_NONE;
        else begin
          found = model_count - 1;
          for (int i = 0; i < model_count; i++) begin
            sum = $realtobits($bitstoreal(model_epoch) + $bitstoreal(model_knots[i]));
            if (!is_nan_bits(sum) && !is_nan_bits(t) &&
                $bitstoreal(sum) >= $bitstoreal(t)) begin
              found = i;
              break;
            end
          end
          r.idx = found[7:0];
        end
      end
      CMD_CLEAR: model_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    knot_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, actual status %0d index %0d",
                 $time, status, knot_index);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
          mismatches++;
        end
        if (knot_index !== exp_r.idx) begin
          $display("%0t: knot_index expected %0d actual %0d", $time, exp_r.idx,
                   knot_index);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [63:0] t);
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    time_bits <= t;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_knot_result(cmd, t));
  endtask

  task automatic random_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_epoch(input logic [63:0] v);
    drain();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'd0;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_epoch = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] rand_bits64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] next_knot_time();
    logic [63:0] last;
    real lr;
    real step;
    if (model_count == 0 || $urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        last = rand_bits64();
        if (last[62:52] == 11'h7FF) last[62] = 1'b0;
        return last;
      end
      return $realtobits(($urandom_range(0, 2000000) - 1000000.0) / 1024.0);
    end
    last = model_knots[model_count-1];
    if ($urandom_range(0, 1) == 0)
      return last[63] ? last - $urandom_range(1, 3) : last + $urandom_range(1, 3);
    lr = $bitstoreal(last);
    step = (lr > 1.0 || lr < -1.0) ? ((lr < 0.0) ? -lr : lr) * 1.0e-3 : 1.0;
    return $realtobits(lr + $urandom_range(1, 1000) * step);
  endfunction

  function automatic logic [63:0] query_time();
    logic [63:0] s;
    if (model_count == 0 || $urandom_range(0, 9) == 0) return rand_bits64();
    s = $realtobits($bitstoreal(model_epoch) +
                    $bitstoreal(model_knots[$urandom_range(0, model_count - 1)]));
    case ($urandom_range(0, 3))
      0: return s;
      1: return s + 1;
      2: return s - 1;
      default: return $realtobits($bitstoreal(s) + $urandom_range(0, 100) - 50.0);
    endcase
  endfunction

  task automatic run_traffic(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_item(CMD_APPEND, next_knot_time());
      else if (r < 78) send_item(CMD_QUERY, query_time());
      else if (r < 82) send_item(CMD_CLEAR, rand_bits64());
      else if (r < 86) send_item(CMD_UNUSED, rand_bits64());
      else if (r < 93) send_item(CMD_APPEND, rand_bits64());
      else send_item(CMD_QUERY, rand_bits64());
      random_gap();
    end
  endtask

  task automatic test_directed();
    send_item(CMD_QUERY, 64'h3FF0_0000_0000_0000);
    send_item(CMD_APPEND, 64'h8000_0000_0000_0000);
    send_item(CMD_APPEND, 64'h0000_0000_0000_0000);
    send_item(CMD_APPEND, 64'h7FF0_0000_0000_0000);
    send_item(CMD_APPEND, 64'hFFF0_0000_0000_0000);
    send_item(CMD_APPEND, QNAN);
    send_item(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_APPEND, 64'h0000_0000_0000_0001);
    send_item(CMD_APPEND, 64'h3FF0_0000_0000_0000);
    send_item(CMD_APPEND, 64'h3FF0_0000_0000_0000);
    send_item(CMD_APPEND, 64'h3FE0_0000_0000_0000);
    send_item(CMD_APPEND, 64'h7FEF_FFFF_FFFF_FFFF);
    send_item(CMD_QUERY, 64'h8000_0000_0000_0000);
    send_item(CMD_QUERY, 64'h0000_0000_0000_0001);
    send_item(CMD_QUERY, 64'h3FF0_0000_0000_0000);
    send_item(CMD_QUERY, 64'h7FF0_0000_0000_0000);
    send_item(CMD_QUERY, 64'hFFF0_0000_0000_0000);
    send_item(CMD_QUERY, QNAN);
    send_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_CLEAR, 64'h0);
    send_item(CMD_QUERY, 64'h0);
  endtask

  task automatic test_full_table();
    send_item(CMD_CLEAR, 64'h0);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(CMD_APPEND, 64'h3FF0_0000_0000_0000 + i);
      random_gap();
    end
    send_item(CMD_APPEND, 64'h4000_0000_0000_0000);
    send_item(CMD_APPEND, QNAN);
    send_item(CMD_QUERY, 64'h3FF0_0000_0000_0080);
    send_item(CMD_QUERY, 64'h4000_0000_0000_0000);
    send_item(CMD_QUERY, 64'h0);
    send_item(CMD_CLEAR, 64'h0);
  endtask

  task automatic test_epoch_sweep();
    logic [63:0] epochs [10];
    epochs = '{64'h0, 64'h3FF0_0000_0000_0000, 64'hC12E_8480_0000_0000,
               64'h7E37_E43C_8800_759C, 64'h7FEF_FFFF_FFFF_FFFF,
               64'h7FF0_0000_0000_0000, QNAN, 64'h8000_0000_0000_0000,
               64'hFFFF_FFFF_FFFF_FFFF, rand_bits64()};
    foreach (epochs[i]) begin
      write_epoch(epochs[i]);
      run_traffic(70);
    end
    write_epoch(64'h0);
    run_traffic(200);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_APPEND;
    time_bits = 64'h0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 64'h0;
    mismatches = 0;
    model_count = 0;
    model_epoch = 64'h0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_table();
    test_epoch_sweep();
    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cks_pkg.sv
rtl/cks_knot_ram.sv
rtl/cks_fadd.sv
rtl/current_knot_search_unit.sv
verif/tb_current_knot_search_unit.sv
